/* src/qpr_pkg.sv */
package qpr_pkg;

	typedef logic signed [31:0] coord_t;
	typedef logic signed [31:0] quat_t;
	typedef logic signed [31:0] entry_t;
	typedef logic signed [63:0] prod_t;

	typedef enum logic [1:0] {
		REG_QX = 2'd0,
		REG_QY = 2'd1,
		REG_QZ = 2'd2,
		REG_QW = 2'd3
	} reg_idx_t;

	localparam quat_t QX_RESET = -32'sd536870912;
	localparam quat_t QY_RESET = 32'sd536870912;
	localparam quat_t QZ_RESET = -32'sd536870912;
	localparam quat_t QW_RESET = 32'sd536870912;

	typedef struct packed {
		coord_t      x;
		coord_t      y;
		coord_t      z;
		logic [31:0] intensity;
		logic        last;
	} point_t;

	typedef struct packed {
		entry_t r00;
		entry_t r01;
		entry_t r02;
		entry_t r10;
		entry_t r11;
		entry_t r12;
		entry_t r20;
		entry_t r21;
		entry_t r22;
	} mat_t;

endpackage

/* src/qpr_matrix.sv */
module qpr_matrix (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            valid_in,
	input  qpr_pkg::point_t pt_in,
	input  qpr_pkg::quat_t  qx,
	input  qpr_pkg::quat_t  qy,
	input  qpr_pkg::quat_t  qz,
	input  qpr_pkg::quat_t  qw,
	output logic            valid_out,
	output qpr_pkg::point_t pt_out,
	output qpr_pkg::mat_t   mat_out
);

	logic            valid_s1;
	qpr_pkg::point_t pt_s1;
	qpr_pkg::prod_t  ww_s1, xx_s1, yy_s1, zz_s1;
	qpr_pkg::prod_t  xy_s1, wz_s1, xz_s1, wy_s1, yz_s1, wx_s1;

	logic            valid_s2;
	qpr_pkg::point_t pt_s2;
	qpr_pkg::mat_t   mat_s2;

	logic signed [65:0] e_ww, e_xx, e_yy, e_zz;
	logic signed [65:0] e_xy, e_wz, e_xz, e_wy, e_yz, e_wx;
	qpr_pkg::mat_t      mat_d;

	function automatic logic signed [65:0] ext66(input qpr_pkg::prod_t p);
		ext66 = $signed({{2{p[63]}}, p});
	endfunction

	function automatic qpr_pkg::entry_t round_entry(input logic signed [65:0] v);
		logic signed [65:0] t;
		logic signed [33:0] h;
		t = v + 66'sd2147483648;
		h = $signed(t[65:32]);
		if (h > 34'sd1073741824) begin
			round_entry = 32'sd1073741824;
		end else if (h < -34'sd1073741824) begin
			round_entry = -32'sd1073741824;
		end else begin
			round_entry = $signed(h[31:0]);
		end
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			valid_s1 <= valid_in;
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		pt_s1 <= pt_in;
		ww_s1 <= qw * qw;
		xx_s1 <= qx * qx;
		yy_s1 <= qy * qy;
		zz_s1 <= qz * qz;
		xy_s1 <= qx * qy;
		wz_s1 <= qw * qz;
		xz_s1 <= qx * qz;
		wy_s1 <= qw * qy;
		yz_s1 <= qy * qz;
		wx_s1 <= qw * qx;
		pt_s2  <= pt_s1;
		mat_s2 <= mat_d;
	end

	always_comb begin
		e_ww = ext66(ww_s1);
		e_xx = ext66(xx_s1);
		e_yy = ext66(yy_s1);
		e_zz = ext66(zz_s1);
		e_xy = ext66(xy_s1);
		e_wz = ext66(wz_s1);
		e_xz = ext66(xz_s1);
		e_wy = ext66(wy_s1);
		e_yz = ext66(yz_s1);
		e_wx = ext66(wx_s1);
		mat_d.r00 = round_entry(e_ww + e_xx - e_yy - e_zz);
		mat_d.r11 = round_entry(e_ww - e_xx + e_yy - e_zz);
		mat_d.r22 = round_entry(e_ww - e_xx - e_yy + e_zz);
		mat_d.r01 = round_entry((e_xy - e_wz) <<< 1);
		mat_d.r10 = round_entry((e_xy + e_wz) <<< 1);
		mat_d.r02 = round_entry((e_xz + e_wy) <<< 1);
		mat_d.r20 = round_entry((e_xz - e_wy) <<< 1);
		mat_d.r12 = round_entry((e_yz - e_wx) <<< 1);
		mat_d.r21 = round_entry((e_yz + e_wx) <<< 1);
	end

	assign valid_out = valid_s2;
	assign pt_out    = pt_s2;
	assign mat_out   = mat_s2;

endmodule

/* src/qpr_apply.sv */
module qpr_apply (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            valid_in,
	input  qpr_pkg::point_t pt_in,
	input  qpr_pkg::mat_t   mat_in,
	output logic            valid_out,
	output qpr_pkg::coord_t x_res,
	output qpr_pkg::coord_t y_res,
	output qpr_pkg::coord_t z_res,
	output logic [31:0]     intensity_res,
	output logic            last_res
);

	logic           valid_s3;
	logic [31:0]    intensity_s3;
	logic           last_s3;
	qpr_pkg::prod_t m00_s3, m01_s3, m02_s3;
	qpr_pkg::prod_t m10_s3, m11_s3, m12_s3;
	qpr_pkg::prod_t m20_s3, m21_s3, m22_s3;

	logic            valid_s4;
	qpr_pkg::coord_t x_s4, y_s4, z_s4;
	logic [31:0]     intensity_s4;
	logic            last_s4;

	function automatic logic signed [65:0] ext66(input qpr_pkg::prod_t p);
		ext66 = $signed({{2{p[63]}}, p});
	endfunction

	function automatic qpr_pkg::coord_t axis_sum(
		input qpr_pkg::prod_t a,
		input qpr_pkg::prod_t b,
		input qpr_pkg::prod_t c
	);
		logic signed [65:0] s;
		logic signed [37:0] h;
		s = ext66(a) + ext66(b) + ext66(c) + 66'sd134217728;
		h = $signed(s[65:28]);
		if (h > 38'sd2147483647) begin
			axis_sum = 32'sh7FFFFFFF;
		end else if (h < -38'sd2147483648) begin
			axis_sum = 32'sh80000000;
		end else begin
			axis_sum = $signed(h[31:0]);
		end
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
		end else begin
			valid_s3 <= valid_in;
			valid_s4 <= valid_s3;
		end
	end

	always_ff @(posedge clk) begin
		intensity_s3 <= pt_in.intensity;
		last_s3      <= pt_in.last;
		m00_s3 <= mat_in.r00 * pt_in.x;
		m01_s3 <= mat_in.r01 * pt_in.y;
		m02_s3 <= mat_in.r02 * pt_in.z;
		m10_s3 <= mat_in.r10 * pt_in.x;
		m11_s3 <= mat_in.r11 * pt_in.y;
		m12_s3 <= mat_in.r12 * pt_in.z;
		m20_s3 <= mat_in.r20 * pt_in.x;
		m21_s3 <= mat_in.r21 * pt_in.y;
		m22_s3 <= mat_in.r22 * pt_in.z;
		x_s4 <= axis_sum(m00_s3, m01_s3, m02_s3);
		y_s4 <= axis_sum(m10_s3, m11_s3, m12_s3);
		z_s4 <= axis_sum(m20_s3, m21_s3, m22_s3);
		intensity_s4 <= intensity_s3;
		last_s4      <= last_s3;
	end

	assign valid_out     = valid_s4;
	assign x_res         = x_s4;
	assign y_res         = y_s4;
	assign z_res         = z_s4;
	assign intensity_res = intensity_s4;
	assign last_res      = last_s4;

endmodule

/* src/quaternion_point_rotator_core.sv */
// Channel  | Handshake                         | Payload
// ---------+-----------------------------------+-----------------------------------------
// input    | start (busy always low)           | x_in, y_in, z_in, intensity_in, last_in
// result   | done, one cycle, no backpressure  | x_out, y_out, z_out, intensity_out, last_out
// config   | psel/penable/pwrite, pready high  | paddr, pwdata, prdata
//
// One transaction per cycle; each result is registered through the stages below, in order.
// Stages: quaternion products, matrix entries, entry-by-coordinate products, axis sums.
// Reset clears the valid bits and loads the quaternion registers with their defaults.
// Nothing stalls: busy is tied low and results are never held off.
module quaternion_point_rotator_core (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   start,
	output logic                   busy,
	input  qpr_pkg::coord_t        x_in,
	input  qpr_pkg::coord_t        y_in,
	input  qpr_pkg::coord_t        z_in,
	input  logic [31:0]            intensity_in,
	input  logic                   last_in,
	output logic                   done,
	output qpr_pkg::coord_t        x_out,
	output qpr_pkg::coord_t        y_out,
	output qpr_pkg::coord_t        z_out,
	output logic [31:0]            intensity_out,
	output logic                   last_out,
	input  logic                   psel,
	input  logic                   penable,
	input  logic                   pwrite,
	input  logic [3:0]             paddr,
	input  logic [31:0]            pwdata,
	output logic [31:0]            prdata,
	output logic                   pready
);

	qpr_pkg::quat_t    qx_q, qy_q, qz_q, qw_q;
	qpr_pkg::reg_idx_t reg_idx;
	logic              cfg_wr;
	qpr_pkg::point_t   pt_in;
	logic              valid_in;
	logic              mat_valid;
	qpr_pkg::point_t   mat_pt;
	qpr_pkg::mat_t     mat;

	assign busy     = 1'b0;
	assign pready   = 1'b1;
	assign valid_in = start & ~busy;
	assign cfg_wr   = psel & penable & pwrite & pready;
	assign reg_idx  = qpr_pkg::reg_idx_t'(paddr[3:2]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			qx_q <= qpr_pkg::QX_RESET;
			qy_q <= qpr_pkg::QY_RESET;
			qz_q <= qpr_pkg::QZ_RESET;
			qw_q <= qpr_pkg::QW_RESET;
		end else if (cfg_wr) begin
			case (reg_idx)
				qpr_pkg::REG_QX: qx_q <= $signed(pwdata);
				qpr_pkg::REG_QY: qy_q <= $signed(pwdata);
				qpr_pkg::REG_QZ: qz_q <= $signed(pwdata);
				qpr_pkg::REG_QW: qw_q <= $signed(pwdata);
				default: begin
				end
			endcase
		end
	end

	always_comb begin
		case (reg_idx)
			qpr_pkg::REG_QX: prdata = qx_q;
			qpr_pkg::REG_QY: prdata = qy_q;
			qpr_pkg::REG_QZ: prdata = qz_q;
			qpr_pkg::REG_QW: prdata = qw_q;
			default:         prdata = '0;
		endcase
	end

	always_comb begin
		pt_in.x         = x_in;
		pt_in.y         = y_in;
		pt_in.z         = z_in;
		pt_in.intensity = intensity_in;
		pt_in.last      = last_in;
	end

	qpr_matrix u_matrix (
		.clk       (clk),
		.arst_n    (arst_n),
		.valid_in  (valid_in),
		.pt_in     (pt_in),
		.qx        (qx_q),
		.qy        (qy_q),
		.qz        (qz_q),
		.qw        (qw_q),
		.valid_out (mat_valid),
		.pt_out    (mat_pt),
		.mat_out   (mat)
	);

	qpr_apply u_apply (
		.clk           (clk),
		.arst_n        (arst_n),
		.valid_in      (mat_valid),
		.pt_in         (mat_pt),
		.mat_in        (mat),
		.valid_out     (done),
		.x_res         (x_out),
		.y_res         (y_out),
		.z_res         (z_out),
		.intensity_res (intensity_out),
		.last_res      (last_out)
	);

endmodule

/* verif/tb_quaternion_point_rotator_core.sv */
module tb_quaternion_point_rotator_core;

	typedef logic signed [127:0] wide_t;

	typedef struct packed {
		qpr_pkg::quat_t x;
		qpr_pkg::quat_t y;
		qpr_pkg::quat_t z;
		qpr_pkg::quat_t w;
	} quat_set_t;

	typedef struct {
		qpr_pkg::point_t pt;
		bit              drain_first;
	} stim_t;

	localparam wide_t ENTRY_HALF = 128'sd2147483648;
	localparam wide_t ENTRY_MAX = 128'sd1073741824;
	localparam wide_t AXIS_HALF = 128'sd134217728;
	localparam wide_t SAT_MAX = 128'sd2147483647;
	localparam wide_t SAT_MIN = -128'sd2147483648;

	localparam qpr_pkg::quat_t Q_ONE = 32'sd1073741824;
	localparam qpr_pkg::quat_t Q_NEG_ONE = -32'sd1073741824;
	localparam qpr_pkg::quat_t Q_TOP = 32'sh7FFFFFFF;
	localparam qpr_pkg::quat_t Q_BOTTOM = 32'sh80000000;
	localparam qpr_pkg::quat_t Q_S45 = 32'sd759250125;

	localparam qpr_pkg::coord_t COORD_TOP = 32'sh7FFFFFFF;
	localparam qpr_pkg::coord_t COORD_BOTTOM = 32'sh80000000;
	localparam qpr_pkg::coord_t COORD_ONE = 32'sd65536;

	localparam int FIXED_SETTINGS = 12;
	localparam int RANDOM_SETTINGS = 13;
	localparam int PHASE_ITEMS = 48;
	localparam int FIRST_PHASE_ITEMS = 30;
	localparam int TAIL_CYCLES = 12;
	localparam int WATCHDOG_LIMIT = 2000;

	logic            clk;
	logic            arst_n;
	logic            start = 1'b0;
	logic            busy;
	qpr_pkg::coord_t x_in = '0;
	qpr_pkg::coord_t y_in = '0;
	qpr_pkg::coord_t z_in = '0;
	logic [31:0]     intensity_in = '0;
	logic            last_in = 1'b0;
	logic            done;
	qpr_pkg::coord_t x_out;
	qpr_pkg::coord_t y_out;
	qpr_pkg::coord_t z_out;
	logic [31:0]     intensity_out;
	logic            last_out;
	logic            psel;
	logic            penable;
	logic            pwrite;
	logic [3:0]      paddr;
	logic [31:0]     pwdata;
	logic [31:0]     prdata;
	logic            pready;

	quat_set_t       rot_cfg;
	stim_t           stim_q[$];
	qpr_pkg::point_t due_points[$];
	stim_t           nxt;
	qpr_pkg::point_t want;
	bit              launch;
	bit              burst = 1'b0;
	int              gap_left = 0;
	int              points_issued = 0;
	int              points_returned = 0;
	int              idle_cycles = 0;
	int              mismatches = 0;

	quaternion_point_rotator_core DUT (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (start),
		.busy         (busy),
		.x_in         (x_in),
		.y_in         (y_in),
		.z_in         (z_in),
		.intensity_in (intensity_in),
		.last_in      (last_in),
		.done         (done),
		.x_out        (x_out),
		.y_out        (y_out),
		.z_out        (z_out),
		.intensity_out(intensity_out),
		.last_out     (last_out),
		.psel         (psel),
		.penable      (penable),
		.pwrite       (pwrite),
		.paddr        (paddr),
		.pwdata       (pwdata),
		.prdata       (prdata),
		.pready       (pready)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic qpr_pkg::entry_t round_entry(wide_t acc);
		wide_t r;
		r = (acc + ENTRY_HALF) >>> 32;
		if (r > ENTRY_MAX) begin
			r = ENTRY_MAX;
		end else if (r < -ENTRY_MAX) begin
			r = -ENTRY_MAX;
		end
		return qpr_pkg::entry_t'(r);
	endfunction

	function automatic qpr_pkg::coord_t axis_sum(
			qpr_pkg::entry_t r0, qpr_pkg::entry_t r1, qpr_pkg::entry_t r2,
			qpr_pkg::coord_t a, qpr_pkg::coord_t b, qpr_pkg::coord_t c);
		wide_t acc;
		acc = wide_t'(r0) * wide_t'(a) + wide_t'(r1) * wide_t'(b)
			+ wide_t'(r2) * wide_t'(c);
		acc = (acc + AXIS_HALF) >>> 28;
		if (acc > SAT_MAX) begin
			acc = SAT_MAX;
		end else if (acc < SAT_MIN) begin
			acc = SAT_MIN;
		end
		return qpr_pkg::coord_t'(acc);
	endfunction

	function automatic qpr_pkg::point_t rotate_point(qpr_pkg::point_t p, quat_set_t q);
		wide_t           qx, qy, qz, qw;
		wide_t           ww, xx, yy, zz, xy, wz, xz, wy, yz, wx;
		qpr_pkg::entry_t r00, r01, r02, r10, r11, r12, r20, r21, r22;
		qpr_pkg::point_t o;
		qx = q.x;
		qy = q.y;
		qz = q.z;
		qw = q.w;
		ww = qw * qw;
		xx = qx * qx;
		yy = qy * qy;
		zz = qz * qz;
		xy = qx * qy;
		wz = qw * qz;
		xz = qx * qz;
		wy = qw * qy;
		yz = qy * qz;
		wx = qw * qx;
		r00 = round_entry(ww + xx - yy - zz);
		r11 = round_entry(ww - xx + yy - zz);
		r22 = round_entry(ww - xx - yy + zz);
		r01 = round_entry((xy - wz) <<< 1);
		r10 = round_entry((xy + wz) <<< 1);
		r02 = round_entry((xz + wy) <<< 1);
		r20 = round_entry((xz - wy) <<< 1);
		r12 = round_entry((yz - wx) <<< 1);
		r21 = round_entry((yz + wx) <<< 1);
		o.x = axis_sum(r00, r01, r02, p.x, p.y, p.z);
		o.y = axis_sum(r10, r11, r12, p.x, p.y, p.z);
		o.z = axis_sum(r20, r21, r22, p.x, p.y, p.z);
		o.intensity = p.intensity;
		o.last = p.last;
		return o;
	endfunction

	function automatic int pick_gap(bit burst_mode);
		int r;
		if (burst_mode) begin
			return 0;
		end
		r = $urandom_range(0, 99);
		if (r < 55) begin
			return 0;
		end
		if (r < 90) begin
			return $urandom_range(1, 3);
		end
		return $urandom_range(8, 40);
	endfunction

	function automatic qpr_pkg::coord_t rand_coord();
		int r;
		r = $urandom_range(0, 99);
		if (r < 5) begin
			return COORD_TOP;
		end
		if (r < 10) begin
			return COORD_BOTTOM;
		end
		if (r < 55) begin
			return qpr_pkg::coord_t'($urandom);
		end
		return qpr_pkg::coord_t'($urandom_range(0, 262144000) - 32'd131072000);
	endfunction

	task automatic push_point(qpr_pkg::coord_t x, qpr_pkg::coord_t y, qpr_pkg::coord_t z,
			logic [31:0] inten, logic lst, bit drain);
		stim_t s;
		s.pt.x = x;
		s.pt.y = y;
		s.pt.z = z;
		s.pt.intensity = inten;
		s.pt.last = lst;
		s.drain_first = drain;
		stim_q.push_back(s);
	endtask

	task automatic push_random_points(int count);
		int drain_at;
		drain_at = $urandom_range(0, count - 1);
		for (int i = 0; i < count; i++) begin
			push_point(rand_coord(), rand_coord(), rand_coord(), $urandom,
				$urandom_range(0, 15) == 0, i == drain_at);
		end
	endtask

	task automatic wait_idle();
		do @(negedge clk);
		while (stim_q.size() != 0 || start || points_issued != points_returned);
	endtask

	task automatic reg_write(qpr_pkg::reg_idx_t idx, qpr_pkg::quat_t val);
		@(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= val;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk);
		while (pready !== 1'b1);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		case (idx)
			qpr_pkg::REG_QX: rot_cfg.x = val;
			qpr_pkg::REG_QY: rot_cfg.y = val;
			qpr_pkg::REG_QZ: rot_cfg.z = val;
			qpr_pkg::REG_QW: rot_cfg.w = val;
			default: begin
			end
		endcase
	endtask

	task automatic program_quat(quat_set_t q);
		reg_write(qpr_pkg::REG_QX, q.x);
		reg_write(qpr_pkg::REG_QY, q.y);
		reg_write(qpr_pkg::REG_QZ, q.z);
		reg_write(qpr_pkg::REG_QW, q.w);
	endtask

	task automatic pick_setting(int idx, output quat_set_t q);
		real cx, cy, cz, cw, norm;
		case (idx)
			0: q = '{32'sd0, 32'sd0, 32'sd0, Q_ONE};
			1: q = '{32'sd0, 32'sd0, 32'sd0, Q_NEG_ONE};
			2: q = '{Q_ONE, Q_ONE, Q_ONE, Q_ONE};
			3: q = '{Q_NEG_ONE, Q_NEG_ONE, Q_NEG_ONE, Q_NEG_ONE};
			4: q = '{Q_TOP, Q_TOP, Q_TOP, Q_TOP};
			5: q = '{Q_BOTTOM, Q_BOTTOM, Q_BOTTOM, Q_BOTTOM};
			6: q = '{Q_TOP, Q_BOTTOM, Q_TOP, Q_BOTTOM};
			7: q = '{32'sd0, 32'sd0, 32'sd0, 32'sd0};
			8: q = '{Q_S45, 32'sd0, 32'sd0, Q_S45};
			9: q = '{32'sd0, Q_S45, 32'sd0, Q_S45};
			10: q = '{32'sd0, 32'sd0, Q_S45, Q_S45};
			11: q = '{Q_ONE, Q_NEG_ONE, 32'sd0, 32'sd0};
			default: begin
				case ($urandom_range(0, 2))
					0: begin
						cx = ($itor($urandom_range(0, 2000000)) - 1.0e6) / 1.0e6;
						cy = ($itor($urandom_range(0, 2000000)) - 1.0e6) / 1.0e6;
						cz = ($itor($urandom_range(0, 2000000)) - 1.0e6) / 1.0e6;
						cw = ($itor($urandom_range(0, 2000000)) - 1.0e6) / 1.0e6;
						norm = $sqrt(cx * cx + cy * cy + cz * cz + cw * cw);
						if (norm < 1.0e-3) begin
							q = '{32'sd0, 32'sd0, 32'sd0, Q_ONE};
						end else begin
							q.x = qpr_pkg::quat_t'($rtoi(cx / norm * 1073741824.0));
							q.y = qpr_pkg::quat_t'($rtoi(cy / norm * 1073741824.0));
							q.z = qpr_pkg::quat_t'($rtoi(cz / norm * 1073741824.0));
							q.w = qpr_pkg::quat_t'($rtoi(cw / norm * 1073741824.0));
						end
					end
					1: begin
						q.x = qpr_pkg::quat_t'($urandom_range(0, 32'd2147483648)
							- 32'd1073741824);
						q.y = qpr_pkg::quat_t'($urandom_range(0, 32'd2147483648)
							- 32'd1073741824);
						q.z = qpr_pkg::quat_t'($urandom_range(0, 32'd2147483648)
							- 32'd1073741824);
						q.w = qpr_pkg::quat_t'($urandom_range(0, 32'd2147483648)
							- 32'd1073741824);
					end
					default: begin
						q.x = qpr_pkg::quat_t'($urandom);
						q.y = qpr_pkg::quat_t'($urandom);
						q.z = qpr_pkg::quat_t'($urandom);
						q.w = qpr_pkg::quat_t'($urandom);
					end
				endcase
			end
		endcase
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start <= 1'b0;
			x_in <= '0;
			y_in <= '0;
			z_in <= '0;
			intensity_in <= '0;
			last_in <= 1'b0;
			gap_left <= 0;
			burst <= 1'b0;
			points_issued <= 0;
		end else begin
			if (start && !busy) begin
				due_points.push_back(rotate_point({x_in, y_in, z_in, intensity_in, last_in},
					rot_cfg));
				points_issued <= points_issued + 1;
			end
			if (!(start && busy)) begin
				launch = 1'b0;
				if (gap_left != 0) begin
					gap_left <= gap_left - 1;
				end else if (stim_q.size() != 0 &&
						!(stim_q[0].drain_first && (start || points_issued != points_returned))) begin
					launch = 1'b1;
				end
				if (launch) begin
					nxt = stim_q.pop_front();
					x_in <= nxt.pt.x;
					y_in <= nxt.pt.y;
					z_in <= nxt.pt.z;
					intensity_in <= nxt.pt.intensity;
					last_in <= nxt.pt.last;
					start <= 1'b1;
					gap_left <= pick_gap(burst);
					if ($urandom_range(0, 39) == 0) begin
						burst <= !burst;
					end
				end else begin
					start <= 1'b0;
					x_in <= $urandom;
					y_in <= $urandom;
					z_in <= $urandom;
					intensity_in <= $urandom;
					last_in <= $urandom_range(0, 1);
				end
			end
		end
	end

	task automatic check_field(string name, logic [31:0] exp_v, logic [31:0] act_v);
		if (exp_v !== act_v) begin
			$display("%0t: %s mismatch, expected %h, actual %h", $time, name, exp_v, act_v);
			mismatches++;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			points_returned <= 0;
		end else if (done) begin
			points_returned <= points_returned + 1;
			if (due_points.size() == 0) begin
				$display("%0t: unexpected transaction, expected none, actual x=%h y=%h z=%h",
					$time, x_out, y_out, z_out);
				mismatches++;
			end else begin
				want = due_points.pop_front();
				check_field("x_out", want.x, x_out);
				check_field("y_out", want.y, y_out);
				check_field("z_out", want.z, z_out);
				check_field("intensity_out", want.intensity, intensity_out);
				check_field("last_out", {31'b0, want.last}, {31'b0, last_out});
			end
		end
	end

	always @(posedge clk) begin
		if (!arst_n) begin
			idle_cycles <= 0;
		end else if ((start && !busy) || done || (psel && penable && pwrite && pready)) begin
			idle_cycles <= 0;
		end else if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("%0t: watchdog timeout, %0d results outstanding", $time,
				due_points.size());
			$display("Testbench completed WITH ERRORS");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	initial begin
		quat_set_t q;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		arst_n = 1'b0;
		rot_cfg = '{qpr_pkg::QX_RESET, qpr_pkg::QY_RESET, qpr_pkg::QZ_RESET,
			qpr_pkg::QW_RESET};
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;

		push_point(32'sd0, 32'sd0, 32'sd0, 32'h0000_0000, 1'b0, 1'b0);
		push_point(COORD_ONE, 32'sd0, 32'sd0, 32'hFFFF_FFFF, 1'b1, 1'b0);
		push_point(32'sd0, COORD_ONE, 32'sd0, 32'h5555_5555, 1'b0, 1'b0);
		push_point(32'sd0, 32'sd0, COORD_ONE, 32'hAAAA_AAAA, 1'b1, 1'b0);
		push_point(COORD_TOP, COORD_TOP, COORD_TOP, 32'h0000_0001, 1'b0, 1'b0);
		push_point(COORD_BOTTOM, COORD_BOTTOM, COORD_BOTTOM, 32'h8000_0000, 1'b1, 1'b0);
		push_point(COORD_TOP, COORD_BOTTOM, COORD_TOP, 32'h7FFF_FFFF, 1'b0, 1'b0);
		push_point(COORD_BOTTOM, COORD_TOP, COORD_BOTTOM, 32'hFFFF_FFFE, 1'b1, 1'b0);
		push_point(COORD_TOP, 32'sd0, 32'sd0, 32'h1234_5678, 1'b0, 1'b0);
		push_point(32'sd0, COORD_BOTTOM, 32'sd0, 32'h8765_4321, 1'b0, 1'b0);
		push_point(32'sd0, 32'sd0, COORD_TOP, 32'h0F0F_0F0F, 1'b1, 1'b0);
		push_point(-32'sd1, -32'sd1, -32'sd1, 32'hF0F0_F0F0, 1'b0, 1'b0);
		push_point(32'sd1, 32'sd1, 32'sd1, 32'h0000_FFFF, 1'b1, 1'b0);
		push_point(-COORD_ONE, COORD_ONE, -COORD_ONE, 32'hFFFF_0000, 1'b0, 1'b1);
		push_random_points(FIRST_PHASE_ITEMS);
		wait_idle();

		for (int ph = 0; ph < FIXED_SETTINGS + RANDOM_SETTINGS; ph++) begin
			pick_setting(ph, q);
			program_quat(q);
			push_random_points(PHASE_ITEMS);
			wait_idle();
		end

		repeat (TAIL_CYCLES) @(posedge clk);
		if (mismatches == 0) begin
			$display("Testbench completed without errors");
		end else begin
			$display("Testbench completed WITH ERRORS");
		end
		$finish;
	end

endmodule
